@@ hdl/slr_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the shuffled Lehmer generator.
package slr_pkg;

  // Lehmer generator constants
  localparam int unsigned    VALUE_W    = 31;
  localparam int unsigned    MULT_W     = 15;
  localparam int unsigned    PROD_W     = VALUE_W + MULT_W;
  localparam logic [MULT_W-1:0]  LCG_MULT   = 15'd16807;
  localparam logic [VALUE_W-1:0] LCG_MOD    = 31'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] SAMPLE_MAX = 31'd2147483389;

  // Default shuffle table depth
  localparam int unsigned TABLE_DEPTH_DEFAULT = 32;

  // Input opcodes
  typedef enum logic {
    OP_DRAW   = 1'b0,
    OP_RESEED = 1'b1
  } opcode_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WARM_FOLD,
    ST_WARM_MUL,
    ST_DRAW_MUL,
    ST_STEP
  } state_e;

  // Seed conditioning: zero and the modulus both map to one
  function automatic logic [VALUE_W-1:0] fix_seed(input logic [VALUE_W-1:0] s);
    logic [VALUE_W-1:0] r;
    r = s;
    if ((s == '0) || (s == LCG_MOD)) begin
      r = VALUE_W'(1);
    end
    return r;
  endfunction

  // Clamp the output just below one
  function automatic logic [VALUE_W-1:0] clamp_sample(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] r;
    r = v;
    if (v > SAMPLE_MAX) begin
      r = SAMPLE_MAX;
    end
    return r;
  endfunction

endpackage

@@ hdl/slr_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module slr_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ hdl/slr_lehmer.sv @@
`timescale 1ns / 1ps
// Lehmer step unit: registered 31x15 product, then fold modulo 2^31-1.
module slr_lehmer (
  input  logic                         clk_i,
  input  logic                         mul_en_i,
  input  logic [slr_pkg::VALUE_W-1:0]  x_i,
  output logic [slr_pkg::VALUE_W-1:0]  next_o
);

  logic [slr_pkg::PROD_W-1:0]  prod_d;
  logic [slr_pkg::PROD_W-1:0]  prod_q;
  logic [slr_pkg::MULT_W-1:0]  hi;
  logic [slr_pkg::VALUE_W-1:0] lo;
  logic [slr_pkg::VALUE_W:0]   sum;

  // Multiply the conditioned value by the generator constant
  assign prod_d = {{slr_pkg::MULT_W{1'b0}}, slr_pkg::fix_seed(x_i)}
                * {{slr_pkg::VALUE_W{1'b0}}, slr_pkg::LCG_MULT};

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
    end
  end

  // Fold high bits onto low bits, one conditional subtract of the modulus
  assign hi  = prod_q[slr_pkg::PROD_W-1:slr_pkg::VALUE_W];
  assign lo  = prod_q[slr_pkg::VALUE_W-1:0];

  always_comb begin
    sum = {{(slr_pkg::VALUE_W + 1 - slr_pkg::MULT_W){1'b0}}, hi} + {1'b0, lo};
    if (sum >= {1'b0, slr_pkg::LCG_MOD}) begin
      sum = sum - {1'b0, slr_pkg::LCG_MOD};
    end
  end

  assign next_o = sum[slr_pkg::VALUE_W-1:0];

endmodule

@@ hdl/shuffled_lehmer_uniform_rng.sv @@
`timescale 1ns / 1ps
// Top level: sequencer, generator state and output register of the shuffled Lehmer RNG.
//
// Park-Miller minimal standard generator (x <- 16807*x mod 2^31-1) behind a
// Bays-Durham shuffle table of TABLE_DEPTH entries held in a synchronous RAM.
// Opcode 1 reseeds (0 and 2^31-1 become 1) and gives no beat.
// Opcode 0 draws one sample, a numerator over 2^31-1 clamped to 2147483389.
// A draw without warm-up: the accept cycle multiplies and reads the table
// entry picked by the last output, the next cycle folds the product, returns
// the entry and writes the fresh generator value back into it. After reset or
// a reseed the first draw runs TABLE_DEPTH+8 warm-up steps first, each a multiply
// then a fold on the shared multiply/fold unit. One result beat can wait in the
// output register while the next item is accepted and worked on.
module shuffled_lehmer_uniform_rng #(
  parameter int unsigned TABLE_DEPTH = slr_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [slr_pkg::VALUE_W-1:0] seed_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [slr_pkg::VALUE_W-1:0] sample_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 8);
  localparam longint unsigned SHUF_DIV = 64'd1 + (64'd2147483646 / 64'(TABLE_DEPTH));

  slr_pkg::state_e state_q, state_d;

  logic [slr_pkg::VALUE_W-1:0] lehmer_q, lehmer_d;
  logic [slr_pkg::VALUE_W-1:0] shuf_q, shuf_d;
  logic                        init_q, init_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [IDX_W-1:0]            idx_q;
  logic                        pend_q, pend_d;
  logic                        out_valid_q, out_valid_d;
  logic [slr_pkg::VALUE_W-1:0] sample_q, sample_d;

  logic                        in_fire;
  logic                        is_reseed;
  logic                        need_warm;
  logic                        out_free;
  logic                        mul_en;
  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [IDX_W-1:0]            rd_idx;
  logic [slr_pkg::VALUE_W-1:0] ram_rdata;
  logic [slr_pkg::VALUE_W-1:0] lcg_next;

  // Table index: last output divided by the shuffle divisor
  function automatic logic [IDX_W-1:0] table_index(input logic [slr_pkg::VALUE_W-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int k = 1; k < TABLE_DEPTH; k++) begin
      if ({1'b0, v} >= 32'(64'(k) * SHUF_DIV)) begin
        idx = IDX_W'(k);
      end
    end
    return idx;
  endfunction

  assign in_stall_o = (state_q != slr_pkg::ST_IDLE) || pend_q;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign is_reseed  = (opcode_i == slr_pkg::OP_RESEED);
  assign need_warm  = init_q || (shuf_q == '0);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign rd_idx     = table_index(shuf_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      slr_pkg::ST_IDLE: begin
        if (in_fire && !is_reseed) begin
          state_d = need_warm ? slr_pkg::ST_WARM_FOLD : slr_pkg::ST_STEP;
        end
      end
      slr_pkg::ST_WARM_FOLD: begin
        state_d = (cnt_q == '0) ? slr_pkg::ST_DRAW_MUL : slr_pkg::ST_WARM_MUL;
      end
      slr_pkg::ST_WARM_MUL: state_d = slr_pkg::ST_WARM_FOLD;
      slr_pkg::ST_DRAW_MUL: state_d = slr_pkg::ST_STEP;
      slr_pkg::ST_STEP:     state_d = slr_pkg::ST_IDLE;
      default:              state_d = slr_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls and state updates
  always_comb begin
    mul_en      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    lehmer_d    = lehmer_q;
    shuf_d      = shuf_q;
    init_d      = init_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && out_stall_i;
    sample_d    = sample_q;
    unique case (state_q)
      slr_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (is_reseed) begin
            lehmer_d = slr_pkg::fix_seed(seed_value_i);
            init_d   = 1'b1;
          end else begin
            mul_en = 1'b1;
            cnt_d  = CNT_W'(TABLE_DEPTH + 7);
          end
        end
      end
      slr_pkg::ST_WARM_FOLD: begin
        // Fill the table from the top entry down
        lehmer_d = lcg_next;
        if (cnt_q < CNT_W'(TABLE_DEPTH)) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_q[IDX_W-1:0];
        end
        if (cnt_q == '0) begin
          shuf_d = lcg_next;
          init_d = 1'b0;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      slr_pkg::ST_WARM_MUL: mul_en = 1'b1;
      slr_pkg::ST_DRAW_MUL: mul_en = 1'b1;
      slr_pkg::ST_STEP: begin
        // Swap the picked entry out and the fresh generator value in
        lehmer_d = lcg_next;
        shuf_d   = ram_rdata;
        ram_we   = 1'b1;
        if (out_free) begin
          out_valid_d = 1'b1;
          sample_d    = slr_pkg::clamp_sample(ram_rdata);
        end else begin
          pend_d = 1'b1;
        end
      end
      default: ;
    endcase
    // Deliver a held result once the output register frees up
    if (pend_q && out_free) begin
      pend_d      = 1'b0;
      out_valid_d = 1'b1;
      sample_d    = slr_pkg::clamp_sample(shuf_q);
    end
  end

  // Control and generator state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slr_pkg::ST_IDLE;
      lehmer_q    <= '0;
      shuf_q      <= '0;
      init_q      <= 1'b1;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lehmer_q    <= lehmer_d;
      shuf_q      <= shuf_d;
      init_q      <= init_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    sample_q <= sample_d;
    if (mul_en) begin
      idx_q <= rd_idx;
    end
  end

  slr_lehmer u_lehmer (
    .clk_i    (clk_i),
    .mul_en_i (mul_en),
    .x_i      (lehmer_q),
    .next_o   (lcg_next)
  );

  slr_ram #(
    .WIDTH (slr_pkg::VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (lcg_next),
    .re_i    (mul_en),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

endmodule
